FILE: rtl/escaped_command_frame_encoder_assert.svh
// assertion macros for the escaped command frame encoder
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ESCAPED_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define ESCAPED_COMMAND_FRAME_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ECFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecfe assertion failed");

// next-cycle implication
`define ECFE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecfe assertion failed");

`else

`define ECFE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ECFE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/ecfe_pkg.sv
// shared types and constants for the escaped command frame encoder
// used by every module of the block; no dependencies
package ecfe_pkg;

  localparam int BODY_BYTES_DEF = 32;
  localparam int LEN_W          = 5;
  localparam int TOTAL_W        = 6;
  localparam int SUM_W          = 16;
  localparam int CMD_W          = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [CMD_W-1:0] CMD_RESET = 16'hFE05;
  localparam logic              REG_COMMAND_CODE = 1'b0;

  localparam logic [7:0] BYTE_SYNC   = 8'hAA;
  localparam logic [7:0] BYTE_ESC    = 8'hDE;
  localparam logic [7:0] BYTE_ESC_AA = 8'hDF;
  localparam logic [7:0] BYTE_ESC_DE = 8'hE0;
  localparam logic [7:0] BYTE_START  = 8'hF0;
  localparam logic [7:0] BYTE_STOP   = 8'h0F;
  localparam logic [TOTAL_W-1:0] LEN_OVERHEAD = 6'd4;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic               hdr;
    logic               tail;
    logic [TOTAL_W-1:0] total;
    logic [CMD_W-1:0]   cmd;
    logic [7:0]         data;
    logic [SUM_W-1:0]   sum;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/ecfe_front.sv
// front end: accepts payload words, tracks the frame and builds jobs
// depends on ecfe_pkg
module ecfe_front import ecfe_pkg::*; #(
  parameter int BODY_BYTES = BODY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  input  logic [CMD_W-1:0] cmd,
  input  q_stat_t          q_stat,
  output logic             push,
  output job_t             job
);

  localparam int MAX_LEN = (BODY_BYTES - 6 < 31) ? BODY_BYTES - 6 : 31;

  logic             in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0] len_clamp;
  logic [TOTAL_W-1:0] total;
  logic [SUM_W-1:0] base;
  logic [LEN_W-1:0] seen_inc;
  logic             tail;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    len_clamp = in_data.payload_length;
    if (len_clamp == '0) begin
      len_clamp = LEN_W'(1);
    end
    if (len_clamp > LEN_W'(MAX_LEN)) begin
      len_clamp = LEN_W'(MAX_LEN);
    end
    total = {1'b0, len_clamp} + LEN_OVERHEAD;

    // header bytes enter the checksum on a frame's first word
    if (!in_frame_r) begin
      base     = SUM_W'(total) + SUM_W'(cmd[7:0]) + SUM_W'(cmd[15:8]);
      flen_nxt = len_clamp;
    end else begin
      base     = sum_r;
      flen_nxt = flen_r;
    end
    sum_nxt      = base + SUM_W'(in_data.payload_byte);
    seen_inc     = seen_r + LEN_W'(1);
    tail         = seen_inc >= flen_nxt;
    in_frame_nxt = !tail;
    seen_nxt     = tail ? '0 : seen_inc;

    job.hdr   = !in_frame_r;
    job.tail  = tail;
    job.total = total;
    job.cmd   = cmd;
    job.data  = in_data.payload_byte;
    job.sum   = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      seen_r     <= '0;
      flen_r     <= '0;
      sum_r      <= '0;
    end else if (push) begin
      in_frame_r <= in_frame_nxt;
      seen_r     <= seen_nxt;
      flen_r     <= flen_nxt;
      sum_r      <= sum_nxt;
    end
  end

endmodule

FILE: rtl/ecfe_queue.sv
// two-entry job queue between front and back end
// depends on ecfe_pkg
module ecfe_queue import ecfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = count_r == 2'd2;
  assign stat.empty = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/ecfe_back.sv
// back end: walks each job through its wire bytes, escaping length, command, body and checksum bytes
// depends on ecfe_pkg
module ecfe_back import ecfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  job_t    head,
  input  q_stat_t q_stat,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  typedef enum logic [3:0] {
    ST_SYNC_A, ST_SYNC_B, ST_LEN_LO, ST_LEN_HI, ST_CMD_LO, ST_CMD_HI,
    ST_BODY, ST_SUM_LO, ST_SUM_HI, ST_END_A, ST_END_B
  } step_t;

  step_t step_r, cur, start_step, end_step;
  logic  started_r;
  logic  phase_r;
  logic  out_valid_r;
  out_t  out_data_r;
  logic  adv, fire, esc, special, step_done;
  logic [7:0] raw, emit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    start_step = head.hdr ? ST_SYNC_A : ST_BODY;
    end_step   = head.tail ? ST_END_B : ST_BODY;
    cur        = started_r ? step_r : start_step;

    unique case (cur)
      ST_SYNC_A: begin raw = BYTE_SYNC;               esc = 1'b0; end
      ST_SYNC_B: begin raw = BYTE_START;              esc = 1'b0; end
      ST_LEN_LO: begin raw = 8'(head.total);          esc = 1'b1; end
      ST_LEN_HI: begin raw = 8'h00;                   esc = 1'b1; end
      ST_CMD_LO: begin raw = head.cmd[7:0];           esc = 1'b1; end
      ST_CMD_HI: begin raw = head.cmd[15:8];          esc = 1'b1; end
      ST_BODY:   begin raw = head.data;               esc = 1'b1; end
      ST_SUM_LO: begin raw = head.sum[7:0];           esc = 1'b1; end
      ST_SUM_HI: begin raw = head.sum[15:8];          esc = 1'b1; end
      ST_END_A:  begin raw = BYTE_SYNC;               esc = 1'b0; end
      ST_END_B:  begin raw = BYTE_STOP;               esc = 1'b0; end
      default:   begin raw = BYTE_SYNC;               esc = 1'b0; end
    endcase

    special = esc && (raw == BYTE_SYNC || raw == BYTE_ESC);
    // escaped bytes go out as two words, escape first
    if (special && !phase_r) begin
      emit      = BYTE_ESC;
      step_done = 1'b0;
    end else if (special) begin
      emit      = (raw == BYTE_SYNC) ? BYTE_ESC_AA : BYTE_ESC_DE;
      step_done = 1'b1;
    end else begin
      emit      = raw;
      step_done = 1'b1;
    end

    adv  = !out_valid_r || !out_stall;
    fire = adv && !q_stat.empty;
    pop  = fire && step_done && (cur == end_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_SYNC_A;
      started_r   <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r          <= 1'b1;
      out_data_r.out_byte  <= emit;
      out_data_r.run_last  <= pop;
      out_data_r.frame_end <= step_done && (cur == ST_END_B);
      phase_r              <= special && !phase_r;
      if (pop) begin
        started_r <= 1'b0;
      end else begin
        started_r <= 1'b1;
        step_r    <= step_done ? step_t'(4'(cur) + 4'd1) : cur;
      end
    end else if (adv) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/escaped_command_frame_encoder.sv
// escaped command frame encoder: one output byte per cycle unless stalled, 1 to 16 per word
// when the back end is idle, a word's first byte passes the job queue, then the output register
// the back end's one-byte-per-cycle output register, unless stalled, sets the pace; a
// 2-entry job queue lets input run ahead
// reset (synchronous, rst_n low): frame state and queue cleared, command_code = FE05
`include "escaped_command_frame_encoder_assert.svh"
module escaped_command_frame_encoder import ecfe_pkg::*; #(
  parameter int BODY_BYTES = BODY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CMD_W-1:0] cmd_r;
  logic             push, pop;
  job_t             job, head;
  q_stat_t          q_stat;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_COMMAND_CODE) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? DATA_W'(cmd_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cmd_r <= pwdata[CMD_W-1:0];
    end
  end

  ecfe_front #(.BODY_BYTES(BODY_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cmd      (cmd_r),
    .q_stat   (q_stat),
    .push     (push),
    .job      (job)
  );

  ecfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  ecfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ECFE_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid && out_data.frame_end, out_data.run_last)
  `ECFE_ASSERT_IMP(a_end_is_stop, clk, rst_n, out_valid && out_data.frame_end, out_data.out_byte == BYTE_STOP)
  `ECFE_ASSERT_NXT(a_push_fills, clk, rst_n, push, !q_stat.empty)
  `ECFE_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, !q_stat.empty)

endmodule
